// ===== hw/rtl/tftprs_pkg.sv =====
package tftprs_pkg;

   localparam logic [15:0] OP_DATA  = 16'd3;
   localparam logic [15:0] OP_ERROR = 16'd5;

   localparam logic [9:0]  FULL_BLOCK_LEN_RESET = 10'd512;
   localparam int          OBUF_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_FIRST = 2'd1,
      PH_RUN   = 2'd2,
      PH_END   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      PK_ACK  = 2'd0,
      PK_ERR  = 2'd1,
      PK_NONE = 2'd2
   } pkt_kind_type;

   typedef enum logic [1:0] {
      OC_ONGOING   = 2'd0,
      OC_COMPLETED = 2'd1,
      OC_REPORTED  = 2'd2
   } outcome_type;

   typedef enum logic {
      KIND_START  = 1'b0,
      KIND_PACKET = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [15:0]   opcode;
      logic [15:0]   rx_block;
      logic [15:0]   source_port;
      logic [9:0]    payload_len;
   } item_type;

   typedef struct packed {
      pkt_kind_type packet_kind;
      logic [15:0]  ack_block;
      logic [15:0]  dest_port;
      logic         write_payload;
      outcome_type  outcome;
      logic [15:0]  retries;
      logic         last;
   } result_type;

   // num: words pushed this cycle (0, 1 or 2)
   typedef struct packed {
      logic [1:0] num;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

// ===== hw/rtl/tftprs_csr.sv =====
module tftprs_csr
   import tftprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [9:0]  full_block_len
);

   logic [9:0] full_block_len_ff;
   logic [9:0] full_block_len_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2];

   always_comb begin
      full_block_len_in = full_block_len_ff;
      if (wr_en) begin
         full_block_len_in = csr_pwdata[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_block_len_ff <= FULL_BLOCK_LEN_RESET;
      end else begin
         full_block_len_ff <= full_block_len_in;
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : {22'd0, full_block_len_ff};
   assign full_block_len = full_block_len_ff;

endmodule

// ===== hw/rtl/tftprs_core.sv =====
module tftprs_core
   import tftprs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [9:0] full_block_len,
   input  logic       item_valid,
   input  item_type   item,
   input  logic [1:0] room,
   output logic       take,
   output push_type   push
);

   phase_type   phase_ff, phase_in;
   logic [15:0] peer_port_ff, peer_port_in;
   logic [15:0] expected_block_ff, expected_block_in;
   logic [15:0] retry_count_ff, retry_count_in;

   logic        is_short;
   logic        is_data;
   logic        is_error;
   logic        stray;
   logic        in_order;
   logic [15:0] prev_block;
   logic [1:0]  need;
   result_type  res0;
   result_type  res1;

   assign is_short   = item.payload_len < full_block_len;
   assign is_data    = item.opcode == OP_DATA;
   assign is_error   = item.opcode == OP_ERROR;
   assign stray      = item.source_port != peer_port_ff;
   assign in_order   = item.rx_block == expected_block_ff;
   assign prev_block = expected_block_ff - 16'd1;

   always_comb begin
      if (item.kind == KIND_START) begin
         need = 2'd0;
      end else if (phase_ff == PH_RUN && stray) begin
         need = 2'd2;
      end else begin
         need = 2'd1;
      end
   end

   assign take = item_valid && (need <= room);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         if (item.kind == KIND_START) begin
            phase_in = PH_FIRST;
         end else begin
            case (phase_ff)
               PH_FIRST: begin
                  if (is_data) begin
                     phase_in = is_short ? PH_END : PH_RUN;
                  end else if (is_error) begin
                     phase_in = PH_END;
                  end
               end
               PH_RUN: begin
                  if (!stray) begin
                     if (is_data && in_order && is_short) begin
                        phase_in = PH_END;
                     end else if (is_error) begin
                        phase_in = PH_END;
                     end
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // session data and result words
   always_comb begin
      peer_port_in      = peer_port_ff;
      expected_block_in = expected_block_ff;
      retry_count_in    = retry_count_ff;

      if (item.kind == KIND_START) begin
         peer_port_in      = 16'd0;
         expected_block_in = 16'd0;
         retry_count_in    = 16'd0;
      end else if (phase_ff == PH_FIRST && is_data) begin
         peer_port_in = item.source_port;
         if (!is_short) begin
            expected_block_in = 16'd2;
         end
      end else if (phase_ff == PH_RUN && !stray && is_data) begin
         if (in_order) begin
            if (!is_short) begin
               expected_block_in = expected_block_ff + 16'd1;
            end
         end else if (retry_count_ff != 16'hFFFF) begin
            retry_count_in = retry_count_ff + 16'd1;
         end
      end

      res0.packet_kind   = PK_NONE;
      res0.ack_block     = 16'd0;
      res0.dest_port     = 16'd0;
      res0.write_payload = 1'b0;
      res0.outcome       = OC_ONGOING;
      res0.retries       = retry_count_in;
      res0.last          = 1'b1;

      res1.packet_kind   = PK_ACK;
      res1.ack_block     = prev_block;
      res1.dest_port     = peer_port_ff;
      res1.write_payload = 1'b0;
      res1.outcome       = OC_ONGOING;
      res1.retries       = retry_count_in;
      res1.last          = 1'b1;

      case (phase_ff)
         PH_FIRST: begin
            if (is_data) begin
               res0.packet_kind   = PK_ACK;
               res0.ack_block     = 16'd1;
               res0.dest_port     = item.source_port;
               res0.write_payload = 1'b1;
               res0.outcome       = is_short ? OC_COMPLETED : OC_ONGOING;
            end else if (is_error) begin
               res0.outcome = OC_REPORTED;
            end
         end
         PH_RUN: begin
            if (stray) begin
               res0.packet_kind = PK_ERR;
               res0.dest_port   = item.source_port;
               res0.last        = 1'b0;
            end else if (is_data) begin
               res0.packet_kind = PK_ACK;
               res0.dest_port   = peer_port_ff;
               if (in_order) begin
                  res0.ack_block     = expected_block_ff;
                  res0.write_payload = 1'b1;
                  res0.outcome       = is_short ? OC_COMPLETED : OC_ONGOING;
               end else begin
                  res0.ack_block = prev_block;
               end
            end else if (is_error) begin
               res0.outcome = OC_REPORTED;
            end
         end
         default: res0.packet_kind = PK_NONE;
      endcase

      push.num  = take ? need : 2'd0;
      push.res0 = res0;
      push.res1 = res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         peer_port_ff      <= 16'd0;
         expected_block_ff <= 16'd0;
         retry_count_ff    <= 16'd0;
      end else begin
         phase_ff <= phase_in;
         if (take) begin
            peer_port_ff      <= peer_port_in;
            expected_block_ff <= expected_block_in;
            retry_count_ff    <= retry_count_in;
         end
      end
   end

endmodule

// ===== hw/rtl/tftprs_obuf.sv =====
module tftprs_obuf
   import tftprs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic [1:0] room,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type head
);

   logic [1:0] count_ff, count_in;
   result_type entry_ff [OBUF_DEPTH];
   result_type entry_in [OBUF_DEPTH];
   logic       pop;
   logic [1:0] kept;

   assign pop = (count_ff != 2'd0) && rsp_tready;

   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      kept = count_ff - {1'b0, pop};
      if (pop) begin
         entry_in[0] = entry_ff[1];
      end
      if (push.num != 2'd0) begin
         if (kept == 2'd0) begin
            entry_in[0] = push.res0;
         end else begin
            entry_in[1] = push.res0;
         end
      end
      if (push.num == 2'd2) begin
         entry_in[1] = push.res1;
      end
      count_in = kept + push.num;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

   assign room       = 2'(OBUF_DEPTH) - count_ff;
   assign rsp_tvalid = count_ff != 2'd0;
   assign head       = entry_ff[0];

endmodule

// ===== hw/rtl/tftp_receive_session.sv =====
// TFTP read-transfer receiver, client side.
// req channel: one word per received packet header or session start.
//   req_tuser selects start (0) or packet (1); req_tdata carries the header.
// rsp channel: zero, one or two words per req word; rsp_tlast marks the
//   final word belonging to a packet. A start word produces no rsp word.
// csr port: full_block_len at byte address 0 (reset 512).
// Path: a req word is registered in the input register at acceptance,
//   then written by the decoder into a two-word output buffer, from which
//   its first rsp word is presented.
// Throughput: one req word per cycle while rsp_tready stays high; a
//   stray-port packet yields two rsp words, waits until the buffer is empty,
//   and its two words then hold back the next req word.
// When rsp_tready is low the buffer fills, then the input register holds,
//   then req_tready drops; nothing is lost or repeated.
// Reset: session idle, peer port, expected block and retry count cleared,
//   buffers empty, full_block_len back to 512.
module tftp_receive_session
   import tftprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] opcode, [31:16] rx_block, [47:32] source_port, [57:48] payload_len
   input  logic [63:0] req_tdata,
   // [0] kind
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] ack_block, [31:16] dest_port, [32] write_payload, [34:33] outcome,
   // [50:35] retries
   output logic [55:0] rsp_tdata,
   // [1:0] packet_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic       item_valid_ff, item_valid_in;
   item_type   item_ff, item_in;
   logic       take;
   logic       req_fire;
   logic [1:0] room;
   logic [9:0] full_block_len;
   push_type   push;
   result_type head;

   tftprs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .full_block_len (full_block_len)
   );

   assign req_tready = !item_valid_ff || take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      item_in.kind        = item_kind_type'(req_tuser);
      item_in.opcode      = req_tdata[15:0];
      item_in.rx_block    = req_tdata[31:16];
      item_in.source_port = req_tdata[47:32];
      item_in.payload_len = req_tdata[57:48];
      item_valid_in = req_fire || (item_valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   tftprs_core u_core (
      .clock          (clock),
      .reset          (reset),
      .full_block_len (full_block_len),
      .item_valid     (item_valid_ff),
      .item           (item_ff),
      .room           (room),
      .take           (take),
      .push           (push)
   );

   tftprs_obuf u_obuf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {5'd0, head.retries, head.outcome, head.write_payload,
                       head.dest_port, head.ack_block};
   assign rsp_tuser = head.packet_kind;
   assign rsp_tlast = head.last;

endmodule
